// ===== hw/rtl/crc8hf_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8hf_pkg
// Shared types, constants and functions for the CRC-8 hex response framer.
// ----------------------------------------------------------------------------
`default_nettype none

package crc8hf_pkg;

  // Reflected Dallas/Maxim polynomial
  localparam logic [7:0] CrcPoly  = 8'h8C;
  localparam logic [7:0] LineFeed = 8'h0A;
  localparam logic [7:0] AsciiZero = 8'h30;
  // 'A' - 10
  localparam logic [7:0] AsciiAlpha = 8'h37;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  // One classified message beat, as queued between front and back
  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_char;
    logic       msg_end;
    logic [7:0] crc;        // CRC after folding in char_byte, if the beat has a character
  } entry_t;

  typedef enum logic [1:0] {
    PH_CHAR,
    PH_HI,
    PH_LO,
    PH_LF
  } phase_e;

  // One byte through the reflected CRC-8, LSB first
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ data[k];
      c  = {1'b0, c[7:1]};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  // Upper-case ASCII hex digit
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'b0000, nib};
    if (nib < 4'd10) begin
      return AsciiZero + ext;
    end
    return AsciiAlpha + ext;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/crc8_hex_response_framer_top.sv =====
// ----------------------------------------------------------------------------
// crc8_hex_response_framer_top
// Passes response characters through and closes each message with its
// CRC-8 (reflected 0x8C, init 0) as two upper-case hex digits and a LF.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one beat per character, with
//   has_char_i marking a real character and msg_end_i closing the message.
//   A beat with msg_end_i and no character frames what came before
//   ("00\n" for an empty message). A beat with neither flag is dropped.
//   Output channel (out_valid_o / out_stall_i): one byte per beat; the
//   closing line feed carries out_last_o.
//   An accepted input beat is written into the queue, then into the
//   output register, before its first output byte is valid.
//   Throughput: one output byte per cycle while out_stall_i is low, set by
//   the single output register of the back part. Character beats therefore
//   go one per cycle; an end-marked beat gives the back part three output
//   bytes to send (four with a character).
//   A four-entry queue decouples the CRC front from the byte sequencer;
//   in_stall_o rises only when that queue is full.
//   Reset: CRC cleared, queue emptied, output invalid. While out_stall_i is
//   high the output byte holds and the queue absorbs up to four beats.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_hex_response_framer_top
  import crc8hf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_byte_i,
  input  wire logic       has_char_i,
  input  wire logic       msg_end_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);

  // Front -> queue
  logic   push;
  entry_t push_entry;
  logic   fifo_full;

  // Queue -> back
  logic   pop;
  entry_t head;
  logic   fifo_empty;

  // CRC and classification
  crc8hf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_byte_i  (char_byte_i),
    .has_char_i   (has_char_i),
    .msg_end_i    (msg_end_i),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // Decoupling queue
  crc8hf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (fifo_empty),
    .full_o       (fifo_full)
  );

  // Byte sequencer and output register
  crc8hf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (fifo_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/crc8hf_front.sv =====
// ----------------------------------------------------------------------------
// crc8hf_front
// Accepts input beats, runs the CRC and queues beats that produce output.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8hf_front
  import crc8hf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_byte_i,
  input  wire logic       has_char_i,
  input  wire logic       msg_end_i,
  input  wire logic       fifo_full_i,
  output logic            push_o,
  output entry_t          push_entry_o
);

  logic [7:0] crc_q, crc_d;
  logic [7:0] crc_next;
  logic       accept;

  assign in_stall_o = fifo_full_i;
  assign accept     = in_valid_i && !fifo_full_i;

  assign crc_next = has_char_i ? crc8_fold(crc_q, char_byte_i) : crc_q;

  always_comb begin
    crc_d = crc_q;
    if (accept) begin
      crc_d = msg_end_i ? 8'h00 : crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= 8'h00;
    end else begin
      crc_q <= crc_d;
    end
  end

  // Beats with neither a character nor an end mark produce nothing
  assign push_o                 = accept && (has_char_i || msg_end_i);
  assign push_entry_o.char_byte = char_byte_i;
  assign push_entry_o.has_char  = has_char_i;
  assign push_entry_o.msg_end   = msg_end_i;
  assign push_entry_o.crc       = crc_next;

endmodule

`default_nettype wire

// ===== hw/rtl/crc8hf_fifo.sv =====
// ----------------------------------------------------------------------------
// crc8hf_fifo
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8hf_fifo
  import crc8hf_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t push_entry_i,
  input  wire logic   pop_i,
  output entry_t      head_o,
  output logic        empty_o,
  output logic        full_o
);

  entry_t            mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoAw:0]   count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (FifoAw+1)'(FifoDepth));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not follow push");

endmodule

`default_nettype wire

// ===== hw/rtl/crc8hf_back.sv =====
// ----------------------------------------------------------------------------
// crc8hf_back
// Expands queued beats into output bytes: character, hex digits, line feed.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8hf_back
  import crc8hf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       empty_i,
  input  wire entry_t     head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);

  phase_e     phase_q, phase_d;
  phase_e     cur_phase;
  logic       advance;
  logic       entry_done;
  logic [7:0] emit_byte;
  logic       emit_last;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  // Output register can take a new byte when empty or being drained
  assign advance = !empty_i && (!out_valid_q || !out_stall_i);

  // Output decode: skip the character slot when the beat has none
  always_comb begin
    cur_phase  = phase_q;
    if (phase_q == PH_CHAR && !head_i.has_char) begin
      cur_phase = PH_HI;
    end
    emit_byte  = head_i.char_byte;
    emit_last  = 1'b0;
    entry_done = 1'b0;
    unique case (cur_phase)
      PH_CHAR: begin
        emit_byte  = head_i.char_byte;
        entry_done = !head_i.msg_end;
      end
      PH_HI: emit_byte = hex_digit(head_i.crc[7:4]);
      PH_LO: emit_byte = hex_digit(head_i.crc[3:0]);
      PH_LF: begin
        emit_byte  = LineFeed;
        emit_last  = 1'b1;
        entry_done = 1'b1;
      end
      default: ;
    endcase
    pop_o = advance && entry_done;
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (advance) begin
      if (entry_done) begin
        phase_d = PH_CHAR;
      end else begin
        unique case (cur_phase)
          PH_CHAR: phase_d = PH_HI;
          PH_HI:   phase_d = PH_LO;
          PH_LO:   phase_d = PH_LF;
          PH_LF:   phase_d = PH_CHAR;
          default: phase_d = PH_CHAR;
        endcase
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CHAR;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  a_last_is_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_byte_q == LineFeed))
    else $error("last beat is not a line feed");

  a_pop_at_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (phase_q == PH_CHAR))
    else $error("phase not rewound after pop");

endmodule

`default_nettype wire

// ===== tb/crc8_hex_response_framer_top_tb.sv =====
// ----------------------------------------------------------------------------
// crc8_hex_response_framer_top_tb
// Self-checking bench for the CRC-8 hex response framer. Message beats go in
// through a bursty driver. A scoreboard predicts the framed byte stream:
// characters pass through, then two hex CRC digits and a LF close each
// message. Every output beat is compared against the oldest expected byte
// while the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_hex_response_framer_top_tb
  import crc8hf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One input beat as queued for the driver
  typedef struct packed {
    logic [7:0] chr;
    logic       has_chr;
    logic       eom;
  } msg_beat_t;

  // One framed output byte
  typedef struct packed {
    logic [7:0] val;
    logic       last;
  } framed_byte_t;

  // Receiver back-pressure styles
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_LONG
  } stall_style_e;

  localparam int unsigned RandBeats = 275;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_byte = 8'h00;
  logic       has_char = 1'b0;
  logic       msg_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  msg_beat_t    pending_beats[$];
  framed_byte_t expected_bytes[$];

  // Scoreboard copy of the running CRC
  logic [7:0] crc_run = 8'h00;

  int unsigned err_count = 0;
  int unsigned beats_accepted = 0;
  int unsigned msgs_framed = 0;
  int unsigned bytes_checked = 0;

  crc8_hex_response_framer_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .char_byte_i(char_byte),
    .has_char_i (has_char),
    .msg_end_i  (msg_end),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_byte_o (out_byte),
    .out_last_o (out_last)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Reflected CRC-8: xor the byte in up front, then eight right shifts,
  // folding the polynomial back in whenever a one drops off the bottom.
  function automatic logic [7:0] crc_fold_char(input logic [7:0] crc_in,
                                               input logic [7:0] ch);
    logic [7:0] r;
    r = crc_in ^ ch;
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    string digits;
    digits = "0123456789ABCDEF";
    return digits[nib];
  endfunction

  // Expected bytes for one accepted beat: the character (if any), then on
  // end of message the CRC in hex, high nibble first, and the closing LF.
  task automatic frame_beat(input msg_beat_t b);
    if (b.has_chr) begin
      expected_bytes.push_back('{val: b.chr, last: 1'b0});
      crc_run = crc_fold_char(crc_run, b.chr);
    end
    if (b.eom) begin
      expected_bytes.push_back('{val: hex_ascii(crc_run[7:4]), last: 1'b0});
      expected_bytes.push_back('{val: hex_ascii(crc_run[3:0]), last: 1'b0});
      expected_bytes.push_back('{val: LineFeed, last: 1'b1});
      crc_run = 8'h00;
      msgs_framed++;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    err_count++;
  endtask

  function automatic void queue_beat(input logic [7:0] c, input logic h,
                                     input logic e);
    pending_beats.push_back('{chr: c, has_chr: h, eom: e});
  endfunction

  // --------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps in between. A beat is
  // taken on an edge with valid high and stall low; the payload only moves
  // once the current beat is gone.
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        frame_beat('{chr: char_byte, has_chr: has_char, eom: msg_end});
        beats_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          msg_beat_t nb;
          nb = pending_beats.pop_front();
          char_byte <= nb.chr;
          has_char  <= nb.has_chr;
          msg_end   <= nb.eom;
          in_valid  <= 1'b1;
          if (burst_left == 0) begin
            // new burst; about a third of bursts get no gap at all
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver back-pressure: the style is redrawn at random, so runs of
  // no stall alternate with random, periodic and long stalls.
  // --------------------------------------------------------------------------
  stall_style_e stall_style = STALL_NONE;
  int unsigned  style_left = 0;
  int unsigned  stall_tick = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style = stall_style_e'($urandom_range(0, 3));
        style_left  = $urandom_range(20, 80);
      end else begin
        style_left--;
      end
      stall_tick++;
      case (stall_style)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_RANDOM: begin
          out_stall <= ($urandom_range(0, 9) < 3);
        end
        STALL_PERIODIC: begin
          out_stall <= (stall_tick % 3 == 0);
        end
        default: begin
          // once raised, tends to stay up
          out_stall <= out_stall ? ($urandom_range(0, 7) != 0)
                                 : ($urandom_range(0, 11) == 0);
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: each accepted output beat against the oldest expected byte
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected output byte 0x%02h last=%0b",
                                  out_byte, out_last));
      end else begin
        framed_byte_t exp_b;
        exp_b = expected_bytes.pop_front();
        if (out_byte !== exp_b.val) begin
          report_mismatch($sformatf("out_byte 0x%02h, want 0x%02h",
                                    out_byte, exp_b.val));
        end
        if (out_last !== exp_b.last) begin
          report_mismatch($sformatf("out_last %0b, want %0b (byte 0x%02h)",
                                    out_last, exp_b.last, exp_b.val));
        end
      end
      bytes_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned rand_beats;
    int unsigned msg_len;
    logic        close_on_char;

    rand_beats = 0;

    // Directed: empty message frames as "00\n"
    queue_beat(8'h00, 1'b0, 1'b1);
    // Idle beat carrying a char it must ignore
    queue_beat(8'hFF, 1'b0, 1'b0);
    // NUL is an ordinary character, not a terminator
    queue_beat(8'h00, 1'b1, 1'b0);
    queue_beat(8'h00, 1'b0, 1'b1);
    // Character and end mark on the same beat
    queue_beat(8'hFF, 1'b1, 1'b1);
    // Single-bit and alternating patterns, idle beat mid-message
    queue_beat(8'h01, 1'b1, 1'b0);
    queue_beat(8'h80, 1'b1, 1'b0);
    queue_beat(8'hFF, 1'b0, 1'b0);
    queue_beat(8'h55, 1'b1, 1'b0);
    queue_beat(8'hAA, 1'b1, 1'b1);
    // Classic check string "123456789", CRC 0xA1
    for (int k = 0; k < 9; k++) begin
      queue_beat(8'h31 + k[7:0], 1'b1, 1'b0);
    end
    queue_beat(8'hA5, 1'b0, 1'b1);

    // Random: mostly well-formed messages of small length, a few long ones,
    // closed either on the last char or by a bare end beat, with idle beats
    // sprinkled in as noise.
    while (rand_beats < RandBeats) begin
      msg_len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40)
                                              : $urandom_range(0, 8);
      close_on_char = (msg_len != 0) && ($urandom_range(0, 1) == 1);
      for (int k = 0; k < msg_len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
        queue_beat(8'($urandom_range(0, 255)), 1'b1,
                   close_on_char && (k == msg_len - 1));
        rand_beats++;
      end
      if (!close_on_char) begin
        queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        rand_beats++;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Let the driver empty its queue, then the framer drain
    while (pending_beats.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    if (expected_bytes.size() != 0) begin
      report_mismatch($sformatf("%0d expected bytes never came out",
                                expected_bytes.size()));
    end

    $display("Run covered %0d input beats framing %0d messages; %0d output bytes checked, %0d errors.",
             beats_accepted, msgs_framed, bytes_checked, err_count);
    if (err_count == 0) begin
      $display("crc8_hex_response_framer_top: match");
    end else begin
      $display("crc8_hex_response_framer_top: mismatch");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2ms;
    $display("TIMEOUT: %0d beats accepted, %0d bytes still expected",
             beats_accepted, expected_bytes.size());
    $display("crc8_hex_response_framer_top: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
